@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define GSI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define GSI_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/gsi_pkg.sv @@
// types, constants and helpers of the grid stencil index generator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package gsi_pkg;

  localparam int GRID_MAX    = 1024;
  localparam int POS_W       = 32;
  localparam int N_W         = 11;
  localparam int CELL_W      = 10;
  localparam int SLOT_W      = 6;
  localparam int Q_W         = $clog2(GRID_MAX) + 1;
  localparam int DIV_W       = POS_W + Q_W;
  localparam int STEP_W      = $clog2(Q_W + 1);
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STENCIL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_N       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SPACING = 2'd2;

  localparam logic [SLOT_W-1:0] CIC_LAST    = 6'd7;
  localparam logic [SLOT_W-1:0] SPLINE_LAST = 6'd63;

  typedef enum logic {
    MODE_CIC    = 1'b0,
    MODE_SPLINE = 1'b1
  } mode_e;

  // wrapped indices per axis for offsets -1, 0, +1, +2
  typedef struct packed {
    logic [3:0][CELL_W-1:0] cx;
    logic [3:0][CELL_W-1:0] cy;
    logic [3:0][CELL_W-1:0] cz;
    mode_e                  mode;
    logic                   last;
    logic                   oor;
  } job_t;

  // cloud-in-cell order, x in bit 0, y in bit 1, z in bit 2
  function automatic logic [2:0] cic_offset(input logic [2:0] k);
    logic [2:0] o;
    case (k)
      3'd0:    o = 3'd0;
      3'd1:    o = 3'd1;
      3'd2:    o = 3'd2;
      3'd3:    o = 3'd4;
      3'd4:    o = 3'd3;
      3'd5:    o = 3'd5;
      3'd6:    o = 3'd6;
      3'd7:    o = 3'd7;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

endpackage

@@ hw/rtl/gsi_front.sv @@
// front end: accepts positions, finds base cells with a shared-step divider
// and wraps the stencil offsets; depends on gsi_pkg
`timescale 1ns / 1ps

module gsi_front import gsi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [POS_W-1:0]   pos_x_i,
  input  logic [POS_W-1:0]   pos_y_i,
  input  logic [POS_W-1:0]   pos_z_i,
  input  logic               particle_last_i,
  input  mode_e              mode_i,
  input  logic [N_W-1:0]     grid_n_i,
  input  logic [POS_W-1:0]   cell_spacing_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output job_t               push_job_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [DIV_W-1:0]      div_q, div_d;
  logic [2:0][POS_W-1:0] rem_q, rem_d;
  logic [2:0][Q_W-1:0]   quo_q, quo_d;
  logic [2:0]            ovf_q, ovf_d;
  logic                  last_q, last_d;
  logic                  in_fire;
  logic [N_W-1:0]        n_eff;
  logic [2:0][N_W-1:0]   base;
  logic [2:0]            sat;
  logic [2:0][3:0][CELL_W-1:0] wrapped;

  assign in_stall_o   = !((state_q == ST_IDLE) || ((state_q == ST_OUT) && push_ready_i));
  assign in_fire      = in_valid_i && !in_stall_o;
  assign push_valid_o = (state_q == ST_OUT);

  always_comb begin
    if (grid_n_i == '0) begin
      n_eff = N_W'(1);
    end else if (grid_n_i > N_W'(GRID_MAX)) begin
      n_eff = N_W'(GRID_MAX);
    end else begin
      n_eff = grid_n_i;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [N_W-1:0] m1, p1, p2, b2;
      sat[a]  = ovf_q[a] || (N_W'(quo_q[a]) >= n_eff);
      base[a] = sat[a] ? (n_eff - N_W'(1)) : N_W'(quo_q[a]);
      m1 = (base[a] == '0) ? (n_eff - N_W'(1)) : (base[a] - N_W'(1));
      p1 = ((base[a] + N_W'(1)) == n_eff) ? '0 : (base[a] + N_W'(1));
      b2 = base[a] + N_W'(2);
      if (n_eff == N_W'(1)) begin
        p2 = '0;
      end else if (b2 >= n_eff) begin
        p2 = b2 - n_eff;
      end else begin
        p2 = b2;
      end
      wrapped[a][0] = CELL_W'(m1);
      wrapped[a][1] = CELL_W'(base[a]);
      wrapped[a][2] = CELL_W'(p1);
      wrapped[a][3] = CELL_W'(p2);
    end
  end

  always_comb begin
    push_job_o.cx   = wrapped[0];
    push_job_o.cy   = wrapped[1];
    push_job_o.cz   = wrapped[2];
    push_job_o.mode = mode_i;
    push_job_o.last = last_q;
    push_job_o.oor  = |sat;
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    div_d   = div_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    last_d  = last_q;
    case (state_q)
      ST_IDLE: begin
      end
      ST_DIV: begin
        for (int a = 0; a < 3; a++) begin
          logic ge;
          ge = (DIV_W'(rem_q[a]) >= div_q);
          if (step_q == STEP_W'(Q_W)) begin
            ovf_d[a] = ge;
          end else begin
            if (ge) begin
              rem_d[a] = rem_q[a] - div_q[POS_W-1:0];
            end
            quo_d[a] = {quo_q[a][Q_W-2:0], ge};
          end
        end
        div_d  = div_q >> 1;
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (push_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (in_fire) begin
      state_d = ST_DIV;
      step_d  = STEP_W'(Q_W);
      div_d   = {cell_spacing_i, {Q_W{1'b0}}};
      rem_d   = {pos_z_i, pos_y_i, pos_x_i};
      quo_d   = '0;
      ovf_d   = '0;
      last_d  = particle_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
    last_q <= last_d;
  end

endmodule

@@ hw/rtl/gsi_queue.sv @@
// short job queue between the front end and the stencil sequencer
// depends on gsi_pkg
`timescale 1ns / 1ps

module gsi_queue import gsi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic head_valid_o,
  output job_t head_job_o,
  input  logic pop_i
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q < CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

@@ hw/rtl/gsi_back.sv @@
// back end: walks the stencil of the head job, one point per cycle unless the output
// stalls or no job is waiting, into the output register; depends on gsi_pkg
`timescale 1ns / 1ps

module gsi_back import gsi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              job_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CELL_W-1:0] cell_x_o,
  output logic [CELL_W-1:0] cell_y_o,
  output logic [CELL_W-1:0] cell_z_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic              run_last_o,
  output logic              batch_last_o,
  output logic              out_of_range_o
);

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              out_valid_q, out_valid_d;
  logic [CELL_W-1:0] cell_x_q, cell_y_q, cell_z_q;
  logic [SLOT_W-1:0] slot_out_q;
  logic              run_last_q, batch_last_q, oor_q;
  logic              advance, is_last;
  logic [1:0]        ix, iy, iz;
  logic [2:0]        off;

  assign advance   = job_valid_i && (!out_valid_q || !out_stall_i);
  assign is_last   = (slot_q == ((job_i.mode == MODE_SPLINE) ? SPLINE_LAST : CIC_LAST));
  assign job_pop_o = advance && is_last;

  always_comb begin
    off = cic_offset(slot_q[2:0]);
    if (job_i.mode == MODE_SPLINE) begin
      ix = slot_q[5:4];
      iy = slot_q[3:2];
      iz = slot_q[1:0];
    end else begin
      ix = off[0] ? 2'd2 : 2'd1;
      iy = off[1] ? 2'd2 : 2'd1;
      iz = off[2] ? 2'd2 : 2'd1;
    end
  end

  always_comb begin
    slot_d      = slot_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (advance) begin
      slot_d      = is_last ? '0 : slot_q + SLOT_W'(1);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cell_x_q     <= job_i.cx[ix];
      cell_y_q     <= job_i.cy[iy];
      cell_z_q     <= job_i.cz[iz];
      slot_out_q   <= slot_q;
      run_last_q   <= is_last;
      batch_last_q <= is_last && job_i.last;
      oor_q        <= job_i.oor;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_x_o       = cell_x_q;
  assign cell_y_o       = cell_y_q;
  assign cell_z_o       = cell_z_q;
  assign slot_o         = slot_out_q;
  assign run_last_o     = run_last_q;
  assign batch_last_o   = batch_last_q;
  assign out_of_range_o = oor_q;

endmodule

@@ hw/rtl/grid_stencil_index_generator.sv @@
// Grid stencil index generator, top level.
// Input channel (in_valid_i / in_stall_o) takes one particle position per item;
// an item is accepted on a rising edge with valid high and stall low.
// Output channel (out_valid_o / out_stall_i) gives one stencil point per item:
// 8 points per particle in cloud-in-cell mode, 64 in spline mode.
// Configuration: write cfg_data_i to register cfg_idx_i when cfg_we_i is high
// (0 stencil mode, 1 grid points per axis, 2 cell spacing); only while idle.
// Front end: the base cell divider runs 12 steps, one per cycle, and the front end
// takes no new particle until it pushes the job; a two-entry job queue follows.
// Back end: one stencil point per cycle unless the output stalls or the queue is
// empty; the back end bounds throughput in spline mode, the divider in cloud-in-cell.
// With an empty queue the first point of a particle passes the divider states, the
// job queue and the output register before it is offered on the output.
// A stall on the output holds the output register; the queue and then the
// front end fill and in_stall_o rises. Reset empties the queue and restores
// mode 0, 64 grid points and spacing 65536.
// Depends on gsi_pkg, gsi_front, gsi_queue, gsi_back and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grid_stencil_index_generator import gsi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [POS_W-1:0]     pos_x_i,
  input  logic [POS_W-1:0]     pos_y_i,
  input  logic [POS_W-1:0]     pos_z_i,
  input  logic                 particle_last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CELL_W-1:0]    cell_x_o,
  output logic [CELL_W-1:0]    cell_y_o,
  output logic [CELL_W-1:0]    cell_z_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic                 run_last_o,
  output logic                 batch_last_o,
  output logic                 out_of_range_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  mode_e            mode_q;
  logic [N_W-1:0]   grid_n_q;
  logic [POS_W-1:0] spacing_q;

  logic q_push_valid, q_push_ready, q_head_valid, q_pop;
  job_t push_job, head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_CIC;
      grid_n_q  <= N_W'(64);
      spacing_q <= POS_W'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STENCIL_MODE: mode_q    <= mode_e'(cfg_data_i[0]);
        CFG_GRID_N:       grid_n_q  <= cfg_data_i[N_W-1:0];
        CFG_CELL_SPACING: spacing_q <= cfg_data_i[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gsi_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .pos_x_i,
    .pos_y_i,
    .pos_z_i,
    .particle_last_i,
    .mode_i         (mode_q),
    .grid_n_i       (grid_n_q),
    .cell_spacing_i (spacing_q),
    .push_valid_o   (q_push_valid),
    .push_ready_i   (q_push_ready),
    .push_job_o     (push_job)
  );

  gsi_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_job_i   (push_job),
    .head_valid_o (q_head_valid),
    .head_job_o   (head_job),
    .pop_i        (q_pop)
  );

  gsi_back u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i    (q_head_valid),
    .job_i          (head_job),
    .job_pop_o      (q_pop),
    .out_valid_o,
    .out_stall_i,
    .cell_x_o,
    .cell_y_o,
    .cell_z_o,
    .slot_o,
    .run_last_o,
    .batch_last_o,
    .out_of_range_o
  );

  `GSI_ASSERT(a_pop_nonempty, q_pop |-> q_head_valid, "job popped from an empty queue")
  `GSI_ASSERT(a_run_last_slot, out_valid_o && run_last_o |-> (slot_o == CIC_LAST || slot_o == SPLINE_LAST), "run end on a slot that is not a stencil end")
  `GSI_ASSERT(a_front_busy, in_valid_i && !in_stall_o |=> in_stall_o, "front took an item while dividing")
  `GSI_ASSERT_RST(a_idle_after_reset, !rst_ni |=> !out_valid_o, "item offered right after reset")

endmodule

@@ verif/tb.sv @@
// self-checking testbench of the grid stencil index generator: directed corners,
// then random particles under several register settings and idling patterns
// depends on gsi_pkg and grid_stencil_index_generator
`timescale 1ns / 1ps

module tb;
  import gsi_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 29;

  typedef struct {
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
    logic [CELL_W-1:0] cz;
    logic [SLOT_W-1:0] slot;
    logic              run_last;
    logic              batch_last;
    logic              oor;
  } stencil_point_t;

  class stencil_scoreboard;
    mode_e          mode;
    bit [N_W-1:0]   grid_n;
    bit [POS_W-1:0] spacing;
    bit [2:0]       cic_order[8];
    stencil_point_t expected_points[$];
    int             mismatches;

    function new();
      mode       = MODE_CIC;
      grid_n     = 64;
      spacing    = 65536;
      mismatches = 0;
      cic_order  = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7};
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_STENCIL_MODE: mode = mode_e'(data[0]);
        CFG_GRID_N:       grid_n = data[N_W-1:0];
        CFG_CELL_SPACING: spacing = data[POS_W-1:0];
        default: ;
      endcase
    endfunction

    function int axis_size();
      if (grid_n == 0) return 1;
      if (grid_n > GRID_MAX) return GRID_MAX;
      return int'(grid_n);
    endfunction

    function int axis_cell(logic [POS_W-1:0] pos, int n, inout bit sat);
      bit [63:0] q;
      if (spacing == 0) q = '1;
      else q = 64'(pos) / 64'(spacing);
      if (q >= 64'(n)) begin
        sat = 1'b1;
        return n - 1;
      end
      return int'(q);
    endfunction

    function int wrap_index(int base, int off, int n);
      return (base + n + off) % n;
    endfunction

    function void push_point(int cx, int cy, int cz, int k, int total, bit last, bit sat);
      stencil_point_t p;
      p.cx         = cx[CELL_W-1:0];
      p.cy         = cy[CELL_W-1:0];
      p.cz         = cz[CELL_W-1:0];
      p.slot       = k[SLOT_W-1:0];
      p.run_last   = (k == total - 1);
      p.batch_last = (k == total - 1) && last;
      p.oor        = sat;
      expected_points.push_back(p);
    endfunction

    // accepted particle: queue its whole stencil
    function void note_particle(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                logic [POS_W-1:0] z, logic last);
      int n;
      int bx;
      int by;
      int bz;
      int k;
      bit sat;
      bit [2:0] o;
      n   = axis_size();
      sat = 1'b0;
      bx  = axis_cell(x, n, sat);
      by  = axis_cell(y, n, sat);
      bz  = axis_cell(z, n, sat);
      if (mode == MODE_CIC) begin
        for (k = 0; k < 8; k++) begin
          o = cic_order[k];
          push_point(wrap_index(bx, o[0], n), wrap_index(by, o[1], n),
                     wrap_index(bz, o[2], n), k, 8, last, sat);
        end
      end else begin
        k = 0;
        for (int a = -1; a <= 2; a++) begin
          for (int b = -1; b <= 2; b++) begin
            for (int c = -1; c <= 2; c++) begin
              push_point(wrap_index(bx, a, n), wrap_index(by, b, n),
                         wrap_index(bz, c, n), k, 64, last, sat);
              k++;
            end
          end
        end
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_point(logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cy,
                              logic [CELL_W-1:0] cz, logic [SLOT_W-1:0] slot,
                              logic run_last, logic batch_last, logic oor);
      stencil_point_t want;
      if (expected_points.size() == 0) begin
        $error("stencil point (%0d,%0d,%0d) slot %0d with none expected",
               cx, cy, cz, slot);
        mismatches++;
        return;
      end
      want = expected_points.pop_front();
      compare_field("cell_x", want.cx, cx);
      compare_field("cell_y", want.cy, cy);
      compare_field("cell_z", want.cz, cz);
      compare_field("slot", want.slot, slot);
      compare_field("run_last", want.run_last, run_last);
      compare_field("batch_last", want.batch_last, batch_last);
      compare_field("out_of_range", want.oor, oor);
    endfunction
  endclass

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [POS_W-1:0]     pos_x_i         = '0;
  logic [POS_W-1:0]     pos_y_i         = '0;
  logic [POS_W-1:0]     pos_z_i         = '0;
  logic                 particle_last_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [CELL_W-1:0]    cell_x_o;
  logic [CELL_W-1:0]    cell_y_o;
  logic [CELL_W-1:0]    cell_z_o;
  logic [SLOT_W-1:0]    slot_o;
  logic                 run_last_o;
  logic                 batch_last_o;
  logic                 out_of_range_o;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i       = '0;
  logic [CFG_W-1:0]     cfg_data_i      = '0;

  stencil_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  grid_stencil_index_generator i_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // result side: random stall, check every accepted point
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_point(cell_x_o, cell_y_o, cell_z_o, slot_o, run_last_o, batch_last_o,
                     out_of_range_o);
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_particle(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                               logic [POS_W-1:0] z, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    pos_x_i         <= x;
    pos_y_i         <= y;
    pos_z_i         <= z;
    particle_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_particle(x, y, z, last);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // upper data bits of the mode and grid writes are random, the block keeps only the register width
  task automatic configure(mode_e m, int n_data, logic [POS_W-1:0] sp);
    write_reg(CFG_STENCIL_MODE, ($urandom & ~32'h1) | 32'(m));
    write_reg(CFG_GRID_N, ($urandom & ~32'h7ff) | 32'(n_data));
    write_reg(CFG_CELL_SPACING, sp);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] rand_pos(int n, logic [POS_W-1:0] sp);
    bit [63:0] p;
    int q;
    q = $urandom_range(n - 1);
    p = 64'(q) * 64'(sp);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        if (sp != 0) p = p + $urandom_range(sp - 1);
      end
      6: ;
      7: p = 0;
      8: p = 64'hffff_ffff;
      default: p = $urandom;
    endcase
    if (sp == 0 || p > 64'hffff_ffff) p = $urandom;
    return p[POS_W-1:0];
  endfunction

  initial begin
    mode_e m;
    int n_data;
    int n_eff;
    logic [POS_W-1:0] sp;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: origin, top cell wrapping, exact saturation
    send_particle(32'd0, 32'd0, 32'd0, 1'b0);
    send_particle(63 * 65536, 63 * 65536 + 65535, 32'd1, 1'b1);
    send_particle(64 * 65536, 32'hffff_ffff, 32'd0, 1'b0);
    send_particle(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    wait_drained();
    configure(MODE_SPLINE, 64, 32'd65536);
    send_particle(32'd0, 32'd0, 32'd0, 1'b0);
    send_particle(62 * 65536, 63 * 65536, 65536, 1'b1);
    wait_drained();
    // zero spacing on a one-point grid
    configure(MODE_SPLINE, 1, 32'd0);
    send_particle(32'd0, 32'd5, 32'hffff_ffff, 1'b1);
    wait_drained();
    // grid size zero acts as one
    configure(MODE_CIC, 0, 32'hffff_ffff);
    send_particle(32'hffff_ffff, 32'hffff_fffe, 32'd0, 1'b1);
    send_particle(32'd0, 32'd0, 32'd0, 1'b0);
    wait_drained();
    // oversized grid clamps to the maximum
    configure(MODE_SPLINE, 2047, 32'd1);
    send_particle(32'd1023, 32'd0, 32'd1022, 1'b0);
    send_particle(32'd1024, 32'd512, 32'd1, 1'b1);
    wait_drained();
    configure(MODE_CIC, 1024, 32'd1);
    send_particle(32'h3ff, 32'h155, 32'h2aa, 1'b1);
    send_particle(32'haaaa_aaaa, 32'h5555_5555, 32'd0, 1'b0);
    wait_drained();
    configure(MODE_CIC, 2, 32'd3);
    send_particle(32'd5, 32'd2, 32'd3, 1'b1);
    send_particle(32'd6, 32'd0, 32'd4, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin m = MODE_SPLINE; n_data = 1024; sp = 32'd1; end
        1: begin m = MODE_CIC; n_data = 1; sp = 32'hffff_ffff; end
        2: begin m = MODE_SPLINE; n_data = 2; sp = 32'd1; end
        default: begin
          m = mode_e'($urandom_range(1));
          case ($urandom_range(7))
            0: n_data = 1;
            1: n_data = 1024;
            2: n_data = $urandom_range(2047);
            default: n_data = $urandom_range(1, 1024);
          endcase
          n_eff = (n_data == 0) ? 1 : (n_data > GRID_MAX) ? GRID_MAX : n_data;
          case ($urandom_range(7))
            0: sp = 32'd1;
            1: sp = 32'hffff_ffff;
            2: sp = 32'd0;
            3: sp = $urandom;
            default: sp = $urandom_range(1, 32'hffff_ffff / n_eff);
          endcase
        end
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      configure(m, n_data, sp);
      n_eff = sb.axis_size();
      repeat (PHASE_ITEMS) begin
        send_particle(rand_pos(n_eff, sp), rand_pos(n_eff, sp), rand_pos(n_eff, sp),
                      $urandom_range(3) == 0);
      end
    end
    wait_drained();

    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/gsi_pkg.sv
hw/rtl/gsi_front.sv
hw/rtl/gsi_queue.sv
hw/rtl/gsi_back.sv
hw/rtl/grid_stencil_index_generator.sv
verif/tb.sv
